// ===== rtl/tvp_pkg.sv =====
`default_nettype none

package tvp_pkg;

  // Fixed-point format of positions, velocities and times
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int STEP_BITS = 16;
  localparam int MAG_BITS  = 31;   // vmax and a magnitudes

  // Shared multiplier: wide operand times word, product kept modulo 2^64
  localparam int MUL_A_BITS = 48;
  localparam int MUL_B_BITS = 32;
  localparam int PROD_BITS  = 64;

  // Shared divider: 48-bit dividend over a 31-bit divisor
  localparam int DIV_NUM_BITS = 48;
  localparam int DIV_DEN_BITS = MAG_BITS;

  // Signed width that holds every position sum before saturation
  localparam int WIDE_BITS = 50;

  // Configuration register map
  localparam int CFG_IDX_BITS = 2;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_VMAX  = 2'd2,
    REG_AMAX  = 2'd3
  } cfg_reg_t;

  // Clamp a wide signed value to the signed word range
  function automatic logic [WORD_BITS-1:0] sat_word(input logic [WIDE_BITS-1:0] x);
    logic [WIDE_BITS-WORD_BITS:0] top;
    top = x[WIDE_BITS-1:WORD_BITS-1];
    if (&top || ~|top) begin
      sat_word = x[WORD_BITS-1:0];
    end else if (x[WIDE_BITS-1]) begin
      sat_word = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      sat_word = {1'b0, {(WORD_BITS-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tvp_mul.sv =====
`default_nettype none

// Two-pass multiplier: one 32x32 array, low half then high half of operand a.
// Product is a*b modulo 2^64, valid in the cycle done is high.
module tvp_mul
  import tvp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [MUL_A_BITS-1:0] op_a,
  input  wire logic [MUL_B_BITS-1:0] op_b,
  output logic                       busy,
  output logic                       done,
  output logic [PROD_BITS-1:0]       prod
);

  localparam int HALF_BITS = MUL_B_BITS;
  localparam int AHI_BITS  = MUL_A_BITS - HALF_BITS;

  typedef enum logic [2:0] {
    MP_IDLE = 3'b001,
    MP_LO   = 3'b010,
    MP_HI   = 3'b100
  } mul_ph_t;

  mul_ph_t                ph_r, ph_nxt;
  logic                   done_r, done_nxt;
  logic [AHI_BITS-1:0]    ahi_r;
  logic [MUL_B_BITS-1:0]  b_r;
  logic [PROD_BITS-1:0]   p_r, lo_r, prod_r;
  logic [HALF_BITS-1:0]   m_a;
  logic [MUL_B_BITS-1:0]  m_b;
  logic [PROD_BITS-1:0]   m_p;

  // Operand select for the shared array
  always_comb begin
    if (ph_r == MP_LO) begin
      m_a = HALF_BITS'(ahi_r);
      m_b = b_r;
    end else begin
      m_a = op_a[HALF_BITS-1:0];
      m_b = op_b;
    end
    m_p = PROD_BITS'(m_a) * PROD_BITS'(m_b);
  end

  // Phase sequencing
  always_comb begin
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    case (ph_r)
      MP_IDLE: begin
        if (start) begin
          ph_nxt = MP_LO;
        end
      end
      MP_LO: begin
        ph_nxt = MP_HI;
      end
      MP_HI: begin
        ph_nxt   = MP_IDLE;
        done_nxt = 1'b1;
      end
      default: begin
        ph_nxt = MP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= MP_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    p_r <= m_p;
    if (ph_r == MP_IDLE) begin
      ahi_r <= op_a[MUL_A_BITS-1:HALF_BITS];
      b_r   <= op_b;
    end
    if (ph_r == MP_LO) begin
      lo_r <= p_r;
    end
    if (ph_r == MP_HI) begin
      prod_r <= lo_r + {p_r[PROD_BITS-HALF_BITS-1:0], {HALF_BITS{1'b0}}};
    end
  end

  assign busy = (ph_r != MP_IDLE) || done_r;
  assign done = done_r;
  assign prod = prod_r;

endmodule

`default_nettype wire

// ===== rtl/tvp_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle; quotient valid while done is high.
module tvp_div
  import tvp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [DIV_NUM_BITS-1:0] num,
  input  wire logic [DIV_DEN_BITS-1:0] den,
  output logic                         busy,
  output logic                         done,
  output logic [DIV_NUM_BITS-1:0]      quo
);

  localparam int CNT_BITS = $clog2(DIV_NUM_BITS);

  logic                    run_r, run_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic [DIV_NUM_BITS-1:0] q_r;
  logic [DIV_DEN_BITS-1:0] rem_r, den_r;
  logic [DIV_DEN_BITS:0]   rem_sh;
  logic [DIV_DEN_BITS+1:0] diff;
  logic                    ge;

  // One trial subtraction
  always_comb begin
    rem_sh = {rem_r, q_r[DIV_NUM_BITS-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_r};
    ge     = !diff[DIV_DEN_BITS+1];
  end

  // Bit counter
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (run_r) begin
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end else if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_BITS'(DIV_NUM_BITS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Remainder and quotient share the shift path
  always_ff @(posedge clk) begin
    if (run_r) begin
      rem_r <= ge ? diff[DIV_DEN_BITS-1:0] : rem_sh[DIV_DEN_BITS-1:0];
      q_r   <= {q_r[DIV_NUM_BITS-2:0], ge};
    end else if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end
  end

  assign busy = run_r || done_r;
  assign done = done_r;
  assign quo  = q_r;

endmodule

`default_nettype wire

// ===== rtl/trapezoidal_velocity_profile.sv =====
`default_nettype none

// Each item takes no multiply once ended, one in cruise, two on the up ramp and
// three on the down ramp, all on the shared multiplier.
// Throughput: one item at a time; the next is taken the cycle after the result loads.
// Profile setup (after reset and after every register write) runs up to two divides
// plus two multiplies, with in_stall high throughout.
// Reset is synchronous, active low: registers to defaults and motion restarts.
module trapezoidal_velocity_profile
  import tvp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // configuration
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [WORD_BITS-1:0]    cfg_data,
  // tick items
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [STEP_BITS-1:0]    in_time_step,
  // results
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [WORD_BITS-1:0]         out_position,
  output logic [WORD_BITS-1:0]         out_velocity,
  output logic [WORD_BITS-1:0]         out_acceleration,
  output logic                         out_ended,
  output logic                         out_profile_error
);

  localparam logic [MAG_BITS-1:0] MAG_ONE = MAG_BITS'(1) << FRAC_BITS;

  typedef enum logic [13:0] {
    S_DERIVE = 14'h0001,
    S_D_TC   = 14'h0002,
    S_D_V1   = 14'h0004,
    S_D_D1   = 14'h0008,
    S_D_CR   = 14'h0010,
    S_IDLE   = 14'h0020,
    S_CHECK  = 14'h0040,
    S_T_RV   = 14'h0080,
    S_T_RD   = 14'h0100,
    S_T_CR   = 14'h0200,
    S_T_DV   = 14'h0400,
    S_T_DW   = 14'h0800,
    S_T_DD   = 14'h1000,
    S_FIN    = 14'h2000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [WORD_BITS-1:0]    start_pos_r, start_pos_nxt;
  logic [WORD_BITS-1:0]    end_pos_r, end_pos_nxt;
  logic [MAG_BITS-1:0]     max_vel_r, max_vel_nxt;
  logic [MAG_BITS-1:0]     max_acc_r, max_acc_nxt;
  logic [WORD_BITS-1:0]    elapsed_r, elapsed_nxt;
  logic [WORD_BITS-1:0]    pos_r, pos_nxt;
  logic [WORD_BITS-1:0]    vel_r, vel_nxt;
  logic                    ended_r, ended_nxt;
  logic                    bad_r, bad_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // payload registers
  logic [WORD_BITS-1:0]    tc_r, tc_nxt;
  logic [WORD_BITS-1:0]    tf_r, tf_nxt;
  logic [WORD_BITS-1:0]    down_r, down_nxt;
  logic [MUL_A_BITS-1:0]   v1_r, v1_nxt;
  logic [MUL_A_BITS-1:0]   tmp_r, tmp_nxt;
  logic [WORD_BITS-1:0]    d2_r, d2_nxt;
  logic [STEP_BITS-1:0]    dt_r, dt_nxt;
  logic [WORD_BITS-1:0]    out_pos_r, out_pos_nxt;
  logic [WORD_BITS-1:0]    out_vel_r, out_vel_nxt;
  logic [WORD_BITS-1:0]    out_acc_r, out_acc_nxt;
  logic                    out_ended_r, out_ended_nxt;
  logic                    out_err_r, out_err_nxt;

  // shared units
  logic                    mul_start, mul_busy, mul_done;
  logic [MUL_A_BITS-1:0]   mul_a;
  logic [MUL_B_BITS-1:0]   mul_b;
  logic [PROD_BITS-1:0]    mul_prod;
  logic                    div_start, div_busy, div_done;
  logic [DIV_NUM_BITS-1:0] div_num;
  logic [DIV_DEN_BITS-1:0] div_den;
  logic [DIV_NUM_BITS-1:0] div_quo;

  // arithmetic around the units
  logic [WORD_BITS:0]      sum_t;
  logic [WORD_BITS-1:0]    t_mid, t_down, t_left;
  logic [MUL_A_BITS-1:0]   prod_q;
  logic [MUL_A_BITS-2:0]   prod_h;
  logic [WIDE_BITS-1:0]    start_w, end_w, d2_w, tf_w;
  logic [WORD_BITS-1:0]    acc_val;

  always_comb begin
    sum_t   = {1'b0, elapsed_r} + (WORD_BITS+1)'(dt_r);
    t_mid   = elapsed_r - {1'b0, tc_r[WORD_BITS-1:1]};
    t_down  = elapsed_r - down_r;
    t_left  = tf_r - elapsed_r;
    prod_q  = mul_prod[PROD_BITS-1:FRAC_BITS];
    prod_h  = mul_prod[PROD_BITS-1:FRAC_BITS+1];
    start_w = WIDE_BITS'($signed(start_pos_r));
    end_w   = WIDE_BITS'($signed(end_pos_r));
    // cruise distance = (end - start) - 2*d1
    d2_w    = end_w - start_w - WIDE_BITS'({prod_h, 1'b0});
    // total time = 2*tc + cruise time
    tf_w    = WIDE_BITS'({tc_r, 1'b0}) + WIDE_BITS'(div_quo);
  end

  // Acceleration by phase of the current elapsed time
  always_comb begin
    if (bad_r) begin
      acc_val = '0;
    end else if (elapsed_r <= tc_r) begin
      acc_val = WORD_BITS'(max_acc_r);
    end else if (elapsed_r < down_r) begin
      acc_val = '0;
    end else begin
      acc_val = '0 - WORD_BITS'(max_acc_r);
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    case (state_r)
      S_D_V1: begin
        mul_a = MUL_A_BITS'(max_acc_r);
        mul_b = tc_r;
      end
      S_D_D1: begin
        mul_a = v1_r;
        mul_b = tc_r;
      end
      S_T_RV: begin
        mul_a = MUL_A_BITS'(max_acc_r);
        mul_b = elapsed_r;
      end
      S_T_RD: begin
        mul_a = tmp_r;
        mul_b = elapsed_r;
      end
      S_T_CR: begin
        mul_a = v1_r;
        mul_b = t_mid;
      end
      S_T_DV: begin
        mul_a = MUL_A_BITS'(t_down);
        mul_b = MUL_B_BITS'(max_acc_r);
      end
      S_T_DW: begin
        mul_a = MUL_A_BITS'(max_acc_r);
        mul_b = t_left;
      end
      S_T_DD: begin
        mul_a = tmp_r;
        mul_b = t_left;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_start = (state_r inside {S_D_V1, S_D_D1, S_T_RV, S_T_RD, S_T_CR, S_T_DV,
                                 S_T_DW, S_T_DD}) && !mul_busy;
  end

  // Operand select for the shared divider
  always_comb begin
    if (state_r == S_D_CR) begin
      div_num = DIV_NUM_BITS'({d2_r, {FRAC_BITS{1'b0}}});
      div_den = max_vel_r;
    end else begin
      div_num = DIV_NUM_BITS'({max_vel_r, {FRAC_BITS{1'b0}}});
      div_den = max_acc_r;
    end
    div_start = ((state_r == S_D_TC) || (state_r == S_D_CR)) && !div_busy;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    start_pos_nxt = start_pos_r;
    end_pos_nxt   = end_pos_r;
    max_vel_nxt   = max_vel_r;
    max_acc_nxt   = max_acc_r;
    elapsed_nxt   = elapsed_r;
    pos_nxt       = pos_r;
    vel_nxt       = vel_r;
    ended_nxt     = ended_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r;
    tc_nxt        = tc_r;
    tf_nxt        = tf_r;
    down_nxt      = down_r;
    v1_nxt        = v1_r;
    tmp_nxt       = tmp_r;
    d2_nxt        = d2_r;
    dt_nxt        = dt_r;
    out_pos_nxt   = out_pos_r;
    out_vel_nxt   = out_vel_r;
    out_acc_nxt   = out_acc_r;
    out_ended_nxt = out_ended_r;
    out_err_nxt   = out_err_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // restart motion, wait for both units to drain
      S_DERIVE: begin
        elapsed_nxt = '0;
        pos_nxt     = start_pos_r;
        vel_nxt     = '0;
        ended_nxt   = 1'b0;
        bad_nxt     = 1'b1;
        if (!mul_busy && !div_busy) begin
          if (max_vel_r == '0 || max_acc_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_D_TC;
          end
        end
      end
      // ramp time tc = vmax / a
      S_D_TC: begin
        if (div_done) begin
          tc_nxt = div_quo[WORD_BITS-1:0];
          if (|div_quo[DIV_NUM_BITS-1:WORD_BITS]) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_D_V1;
          end
        end
      end
      // peak ramp velocity v1 = a * tc
      S_D_V1: begin
        if (mul_done) begin
          v1_nxt    = prod_q;
          state_nxt = S_D_D1;
        end
      end
      // ramp distance, then cruise distance must be positive
      S_D_D1: begin
        if (mul_done) begin
          d2_nxt = d2_w[WORD_BITS-1:0];
          if (d2_w[WIDE_BITS-1] || d2_w == '0) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_D_CR;
          end
        end
      end
      // cruise time and total time
      S_D_CR: begin
        if (div_done) begin
          tf_nxt   = tf_w[WORD_BITS-1:0];
          down_nxt = tf_w[WORD_BITS-1:0] - tc_r;
          if (~|tf_w[WIDE_BITS-1:WORD_BITS]) begin
            bad_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          dt_nxt    = in_time_step;
          state_nxt = S_CHECK;
        end
      end
      // advance time or stop
      S_CHECK: begin
        if (ended_r) begin
          state_nxt = S_FIN;
        end else if (bad_r || sum_t >= {1'b0, tf_r}) begin
          ended_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          elapsed_nxt = sum_t[WORD_BITS-1:0];
          if (sum_t[WORD_BITS-1:0] <= tc_r) begin
            state_nxt = S_T_RV;
          end else if (sum_t[WORD_BITS-1:0] <= down_r) begin
            state_nxt = S_T_CR;
          end else begin
            state_nxt = S_T_DV;
          end
        end
      end
      // up ramp: v = a*t, p = start + v*t/2
      S_T_RV: begin
        if (mul_done) begin
          tmp_nxt   = prod_q;
          vel_nxt   = sat_word(WIDE_BITS'(prod_q));
          state_nxt = S_T_RD;
        end
      end
      S_T_RD: begin
        if (mul_done) begin
          pos_nxt   = sat_word(start_w + WIDE_BITS'(prod_h));
          state_nxt = S_FIN;
        end
      end
      // cruise: p = start + v1*(t - tc/2), v = vmax
      S_T_CR: begin
        if (mul_done) begin
          pos_nxt   = sat_word(start_w + WIDE_BITS'(prod_q));
          vel_nxt   = WORD_BITS'(max_vel_r);
          state_nxt = S_FIN;
        end
      end
      // down ramp: v = vmax - a*(t - down), p = end - a*x*x/2
      S_T_DV: begin
        if (mul_done) begin
          vel_nxt   = sat_word(WIDE_BITS'(max_vel_r) - WIDE_BITS'(prod_q));
          state_nxt = S_T_DW;
        end
      end
      S_T_DW: begin
        if (mul_done) begin
          tmp_nxt   = prod_q;
          state_nxt = S_T_DD;
        end
      end
      S_T_DD: begin
        if (mul_done) begin
          pos_nxt   = sat_word(end_w - WIDE_BITS'(prod_h));
          state_nxt = S_FIN;
        end
      end
      // load the result register once it is free
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_pos_nxt   = pos_r;
          out_vel_nxt   = vel_r;
          out_acc_nxt   = acc_val;
          out_ended_nxt = ended_r;
          out_err_nxt   = bad_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_DERIVE;
      end
    endcase

    // register write restarts the profile
    if (cfg_we) begin
      state_nxt = S_DERIVE;
      case (cfg_index)
        REG_START: start_pos_nxt = cfg_data;
        REG_END:   end_pos_nxt   = cfg_data;
        REG_VMAX:  max_vel_nxt   = cfg_data[MAG_BITS-1:0];
        REG_AMAX:  max_acc_nxt   = cfg_data[MAG_BITS-1:0];
        default:   state_nxt     = state_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_DERIVE;
      start_pos_r <= '0;
      end_pos_r   <= '0;
      max_vel_r   <= MAG_ONE;
      max_acc_r   <= MAG_ONE;
      elapsed_r   <= '0;
      pos_r       <= '0;
      vel_r       <= '0;
      ended_r     <= 1'b0;
      bad_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_pos_r <= start_pos_nxt;
      end_pos_r   <= end_pos_nxt;
      max_vel_r   <= max_vel_nxt;
      max_acc_r   <= max_acc_nxt;
      elapsed_r   <= elapsed_nxt;
      pos_r       <= pos_nxt;
      vel_r       <= vel_nxt;
      ended_r     <= ended_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tc_r        <= tc_nxt;
    tf_r        <= tf_nxt;
    down_r      <= down_nxt;
    v1_r        <= v1_nxt;
    tmp_r       <= tmp_nxt;
    d2_r        <= d2_nxt;
    dt_r        <= dt_nxt;
    out_pos_r   <= out_pos_nxt;
    out_vel_r   <= out_vel_nxt;
    out_acc_r   <= out_acc_nxt;
    out_ended_r <= out_ended_nxt;
    out_err_r   <= out_err_nxt;
  end

  tvp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  tvp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_position      = out_pos_r;
  assign out_velocity      = out_vel_r;
  assign out_acceleration  = out_acc_r;
  assign out_ended         = out_ended_r;
  assign out_profile_error = out_err_r;

  // The two shared units never run at once
  assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !div_busy)
    else $error("multiplier started while divider busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !mul_busy)
    else $error("divider started while multiplier busy");

  // An accepted item holds off the next one
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted back to back");

  // Ended is sticky until the profile restarts
  assert property (@(posedge clk) disable iff (!rst_n)
    (ended_r && state_r != S_DERIVE && !cfg_we) |=> ended_r)
    else $error("ended flag dropped without restart");

  // A valid profile has the down ramp start at or after the up ramp ends
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !bad_r) |-> (down_r >= tc_r))
    else $error("profile phases out of order");

  // A bad profile reports no acceleration
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_profile_error) |-> (out_acceleration == '0))
    else $error("acceleration reported on bad profile");

endmodule

`default_nettype wire
